// ===== hw/rtl/qsc_pkg.sv =====
// Shared types and constants for the quad squareness check.
`timescale 1ns / 1ps

package qsc_pkg;

    // Configuration port
    localparam int CFG_W = 16;
    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef logic [1:0]       cfg_index_t;

    localparam cfg_index_t REG_DPI    = 2'd0;
    localparam cfg_index_t REG_SPREAD = 2'd1;
    localparam cfg_index_t REG_OPP    = 2'd2;
    localparam cfg_index_t REG_ADJ    = 2'd3;

    localparam cfg_word_t DPI_RESET    = 16'd1152;
    localparam cfg_word_t SPREAD_RESET = 16'd655;
    localparam cfg_word_t OPP_RESET    = 16'd64881;
    localparam cfg_word_t ADJ_RESET    = 16'd655;

    // Side length root width; independent of the coordinate width.
    localparam int LEN_W = 25;

    // Result width in millimetres, Q.8.
    localparam int WIDTH_W = 20;
    typedef logic [WIDTH_W-1:0] width_t;
    localparam width_t WIDTH_MAX = '1;

    // 25.4 / 4 * 5 * 2^8 folded into one integer scale: 127 * 64.
    localparam int MM_SCALE = 8128;

    // Fixed-point alignment of the spread and cosine tests.
    localparam int SPREAD_SHIFT = 15;
    localparam int COS_SHIFT    = 16;

endpackage

// ===== hw/rtl/qsc_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, several lanes.
`timescale 1ns / 1ps

module qsc_sqrt_pipe #(
    parameter int ROOT_W = 25,
    parameter int LANES  = 4,
    parameter int SB_W   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad [LANES],
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root [LANES],
    output logic [SB_W-1:0]       out_sb
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int TMP_W = ROOT_W + 4;

    logic              valid_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W][LANES];
    logic [REM_W-1:0]  rem_reg   [ROOT_W][LANES];
    logic [ROOT_W-1:0] root_reg  [ROOT_W][LANES];
    logic [SB_W-1:0]   sb_reg    [ROOT_W];

    genvar s, l;
    generate
        for (s = 0; s < ROOT_W; s++)
        begin : g_stage
            logic              stg_valid;
            logic [RAD_W-1:0]  stg_rad  [LANES];
            logic [REM_W-1:0]  stg_rem  [LANES];
            logic [ROOT_W-1:0] stg_root [LANES];
            logic [SB_W-1:0]   stg_sb;

            // Stage inputs come from the port or from the previous stage.
            if (s == 0)
            begin : g_first
                assign stg_valid = in_valid;
                assign stg_sb    = in_sb;
                for (l = 0; l < LANES; l++)
                begin : g_init
                    assign stg_rad[l]  = in_rad[l];
                    assign stg_rem[l]  = '0;
                    assign stg_root[l] = '0;
                end
            end
            else
            begin : g_next
                assign stg_valid = valid_reg[s-1];
                assign stg_sb    = sb_reg[s-1];
                assign stg_rad   = rad_reg[s-1];
                assign stg_rem   = rem_reg[s-1];
                assign stg_root  = root_reg[s-1];
            end

            // Valid bit of this stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= stg_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sb_reg[s] <= stg_sb;
                end
            end

            // One restoring root step per lane: bring down two radicand bits.
            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [TMP_W-1:0] tmp;
                logic [TMP_W-1:0] trial;
                logic             take;

                assign tmp   = {stg_rem[l], stg_rad[l][RAD_W-1-2*s -: 2]};
                assign trial = {2'b00, stg_root[l], 2'b01};
                assign take  = (tmp >= trial);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[s][l]  <= stg_rad[l];
                        rem_reg[s][l]  <= take ? REM_W'(tmp - trial) : REM_W'(tmp);
                        root_reg[s][l] <= {stg_root[l][ROOT_W-2:0], take};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_sb    = sb_reg[ROOT_W-1];

endmodule

// ===== hw/rtl/qsc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module qsc_div_pipe #(
    parameter int QUO_W = 20,
    parameter int DEN_W = 31,
    parameter int SB_W  = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [QUO_W+DEN_W-1:0]  in_num,
    input  logic [DEN_W-1:0]        in_den,
    input  logic [SB_W-1:0]         in_sb,
    output logic                    out_valid,
    output logic [QUO_W-1:0]        out_quo,
    output logic [SB_W-1:0]         out_sb
);

    localparam int REM_W = QUO_W + DEN_W;

    logic             valid_reg [QUO_W];
    logic [REM_W-1:0] rem_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [QUO_W-1:0] quo_reg   [QUO_W];
    logic [SB_W-1:0]  sb_reg    [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            localparam int BIT = QUO_W - 1 - s;

            logic             stg_valid;
            logic [REM_W-1:0] stg_rem;
            logic [DEN_W-1:0] stg_den;
            logic [QUO_W-1:0] stg_quo;
            logic [SB_W-1:0]  stg_sb;
            logic [REM_W-1:0] shifted;
            logic             take;

            if (s == 0)
            begin : g_first
                assign stg_valid = in_valid;
                assign stg_rem   = in_num;
                assign stg_den   = in_den;
                assign stg_quo   = '0;
                assign stg_sb    = in_sb;
            end
            else
            begin : g_next
                assign stg_valid = valid_reg[s-1];
                assign stg_rem   = rem_reg[s-1];
                assign stg_den   = den_reg[s-1];
                assign stg_quo   = quo_reg[s-1];
                assign stg_sb    = sb_reg[s-1];
            end

            // Trial subtract of the divisor aligned to this quotient bit.
            assign shifted = REM_W'(stg_den) << BIT;
            assign take    = (stg_rem >= shifted);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= stg_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? (stg_rem - shifted) : stg_rem;
                    den_reg[s] <= stg_den;
                    quo_reg[s] <= stg_quo | (QUO_W'(take) << BIT);
                    sb_reg[s]  <= stg_sb;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_sb    = sb_reg[QUO_W-1];

endmodule

// ===== hw/rtl/quad_squareness_check_unit.sv =====
// Top level of the quad squareness check: side lengths, tests and width in mm.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// finished result waits at the output, so nothing is lost or repeated.
// Depth is set by the two root units (25 and 28 stages) and the 20-stage divider.
// Reset clears all valid bits and loads the default configuration.
`timescale 1ns / 1ps

module quad_squareness_check_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  qsc_pkg::cfg_index_t           cfg_index,
    input  qsc_pkg::cfg_word_t            cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            corner0_x,
    input  logic signed [15:0]            corner0_y,
    input  logic signed [15:0]            corner1_x,
    input  logic signed [15:0]            corner1_y,
    input  logic signed [15:0]            corner2_x,
    input  logic signed [15:0]            corner2_y,
    input  logic signed [15:0]            corner3_x,
    input  logic signed [15:0]            corner3_y,
    input  logic                          last_quad,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_square,
    output qsc_pkg::width_t               width_mm,
    output logic                          last_result
);

    import qsc_pkg::*;

    localparam int EXTRA   = 24 - COORD_WIDTH;
    localparam int VEC_W   = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * VEC_W;
    localparam int SQ_W    = 2 * COORD_WIDTH + 2;
    localparam int DOT_W   = 2 * COORD_WIDTH + 3;
    localparam int RAD_A_W = 2 * LEN_W;
    localparam int SUM_W   = LEN_W + 2;
    localparam int DEV_W   = SUM_W + 1;
    localparam int DMAG_W  = SUM_W;
    localparam int D2_W    = 2 * DMAG_W;
    localparam int R_W     = SUM_W + 1;
    localparam int SUMD2_W = 2 * R_W;
    localparam int P_W     = 2 * LEN_W;
    localparam int LIMP_W  = P_W + CFG_W;
    localparam int CMP_W   = LIMP_W + 2;
    localparam int COS_SH  = 2 * EXTRA + COS_SHIFT;
    localparam int SPR_W   = SUM_W + CFG_W;
    localparam int NUM_W   = SUM_W + 14;
    localparam int DEN_W   = CFG_W + 3 + EXTRA;
    localparam int DIV_W   = DEN_W + WIDTH_W;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot01;
        logic signed [DOT_W-1:0] dot02;
        logic                    zero;
        logic                    last;
    } sb_a_t;

    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic [P_W-1:0]          p02;
        logic [P_W-1:0]          p01;
        logic signed [DOT_W-1:0] dot01;
        logic signed [DOT_W-1:0] dot02;
        logic                    zero;
        logic                    last;
    } sb_b_t;

    typedef struct packed {
        logic ok;
        logic sat;
        logic last;
    } sb_d_t;

    // Configuration registers
    cfg_word_t dpi_reg, spread_reg, opp_reg, adj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpi_reg    <= DPI_RESET;
            spread_reg <= SPREAD_RESET;
            opp_reg    <= OPP_RESET;
            adj_reg    <= ADJ_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DPI:    dpi_reg    <= cfg_wdata;
                REG_SPREAD: spread_reg <= cfg_wdata;
                REG_OPP:    opp_reg    <= cfg_wdata;
                REG_ADJ:    adj_reg    <= cfg_wdata;
                default:    dpi_reg    <= dpi_reg;
            endcase
        end
    end

    // Global advance: every stage moves unless a result waits at the output and is not taken.
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Stage 1: capture corners, keeping the low COORD_WIDTH bits of each field.
    logic                          v1_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg [4];
    logic signed [COORD_WIDTH-1:0] cy_reg [4];
    logic                          last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= COORD_WIDTH'($unsigned(corner0_x));
            cy_reg[0] <= COORD_WIDTH'($unsigned(corner0_y));
            cx_reg[1] <= COORD_WIDTH'($unsigned(corner1_x));
            cy_reg[1] <= COORD_WIDTH'($unsigned(corner1_y));
            cx_reg[2] <= COORD_WIDTH'($unsigned(corner2_x));
            cy_reg[2] <= COORD_WIDTH'($unsigned(corner2_y));
            cx_reg[3] <= COORD_WIDTH'($unsigned(corner3_x));
            cy_reg[3] <= COORD_WIDTH'($unsigned(corner3_y));
            last1_reg <= last_quad;
        end
    end

    // Stage 2: side vectors, corner j to corner j+1.
    logic                    v2_reg;
    logic signed [VEC_W-1:0] vx_reg [4];
    logic signed [VEC_W-1:0] vy_reg [4];
    logic                    last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                vx_reg[j] <= VEC_W'(cx_reg[2'(j + 1)]) - VEC_W'(cx_reg[j]);
                vy_reg[j] <= VEC_W'(cy_reg[2'(j + 1)]) - VEC_W'(cy_reg[j]);
            end
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: squares and the dot product terms.
    logic                     v3_reg;
    logic signed [PROD_W-1:0] sqx_reg [4];
    logic signed [PROD_W-1:0] sqy_reg [4];
    logic signed [PROD_W-1:0] x01_reg, y01_reg, x02_reg, y02_reg;
    logic                     last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                sqx_reg[j] <= PROD_W'(vx_reg[j]) * PROD_W'(vx_reg[j]);
                sqy_reg[j] <= PROD_W'(vy_reg[j]) * PROD_W'(vy_reg[j]);
            end
            x01_reg   <= PROD_W'(vx_reg[0]) * PROD_W'(vx_reg[1]);
            y01_reg   <= PROD_W'(vy_reg[0]) * PROD_W'(vy_reg[1]);
            x02_reg   <= PROD_W'(vx_reg[0]) * PROD_W'(vx_reg[2]);
            y02_reg   <= PROD_W'(vy_reg[0]) * PROD_W'(vy_reg[2]);
            last3_reg <= last2_reg;
        end
    end

    // Stage 4: squared lengths, dot products and the zero-side flag.
    logic                    v4_reg;
    logic [SQ_W-1:0]         sq_reg [4];
    logic [SQ_W-1:0]         sq_next [4];
    logic                    zero4_reg;
    logic signed [DOT_W-1:0] dot01_4_reg, dot02_4_reg;
    logic                    last4_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sq_next[j] = SQ_W'($unsigned(sqx_reg[j])) + SQ_W'($unsigned(sqy_reg[j]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg      <= sq_next;
            zero4_reg   <= (sq_next[0] == '0) || (sq_next[1] == '0) ||
                           (sq_next[2] == '0) || (sq_next[3] == '0);
            dot01_4_reg <= DOT_W'(x01_reg) + DOT_W'(y01_reg);
            dot02_4_reg <= DOT_W'(x02_reg) + DOT_W'(y02_reg);
            last4_reg   <= last3_reg;
        end
    end

    // Side lengths: floor(sqrt(sq << 2E)).
    logic [RAD_A_W-1:0] rad_a [4];
    logic               va_out;
    logic [LEN_W-1:0]   len_a [4];
    sb_a_t              sb_a_in, sb_a_out;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rad_a[j] = RAD_A_W'(sq_reg[j]) << (2 * EXTRA);
        end
    end

    assign sb_a_in = '{dot01: dot01_4_reg, dot02: dot02_4_reg,
                       zero: zero4_reg, last: last4_reg};

    qsc_sqrt_pipe #(
        .ROOT_W (LEN_W),
        .LANES  (4),
        .SB_W   ($bits(sb_a_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_rad    (rad_a),
        .in_sb     (sb_a_in),
        .out_valid (va_out),
        .out_root  (len_a),
        .out_sb    (sb_a_out)
    );

    // Stage 5: sum of lengths, deviations and length products.
    logic                    v5_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [SUM_W-1:0]        sum5_reg;
    logic signed [DEV_W-1:0] dev_reg [4];
    logic [P_W-1:0]          p02_5_reg, p01_5_reg;
    sb_a_t                   sb5_reg;

    assign sum_next = SUM_W'(len_a[0]) + SUM_W'(len_a[1]) +
                      SUM_W'(len_a[2]) + SUM_W'(len_a[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= va_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum5_reg <= sum_next;
            for (int j = 0; j < 4; j++)
            begin
                dev_reg[j] <= $signed({1'b0, len_a[j], 2'b00}) - $signed({1'b0, sum_next});
            end
            p02_5_reg <= P_W'(len_a[0]) * P_W'(len_a[2]);
            p01_5_reg <= P_W'(len_a[0]) * P_W'(len_a[1]);
            sb5_reg   <= sb_a_out;
        end
    end

    // Stage 6: squared deviations.
    logic              v6_reg;
    logic [DMAG_W-1:0] dmag [4];
    logic [D2_W-1:0]   d2_reg [4];
    logic [SUM_W-1:0]  sum6_reg;
    logic [P_W-1:0]    p02_6_reg, p01_6_reg;
    sb_a_t             sb6_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            dmag[j] = dev_reg[j][DEV_W-1] ? DMAG_W'(-dev_reg[j]) : DMAG_W'(dev_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                d2_reg[j] <= D2_W'(dmag[j]) * D2_W'(dmag[j]);
            end
            sum6_reg  <= sum5_reg;
            p02_6_reg <= p02_5_reg;
            p01_6_reg <= p01_5_reg;
            sb6_reg   <= sb5_reg;
        end
    end

    // Stage 7: sum of squared deviations.
    logic               v7_reg;
    logic [SUMD2_W-1:0] sumd2_reg;
    sb_b_t              sb_b_in, sb_b_out;
    logic               vb_out;
    logic [R_W-1:0]     root_b [1];
    logic [SUMD2_W-1:0] rad_b [1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumd2_reg <= SUMD2_W'(d2_reg[0]) + SUMD2_W'(d2_reg[1]) +
                         SUMD2_W'(d2_reg[2]) + SUMD2_W'(d2_reg[3]);
            sb_b_in   <= '{sum: sum6_reg, p02: p02_6_reg, p01: p01_6_reg,
                           dot01: sb6_reg.dot01, dot02: sb6_reg.dot02,
                           zero: sb6_reg.zero, last: sb6_reg.last};
        end
    end

    assign rad_b[0] = sumd2_reg;

    // Deviation root r, where sd = r / 8.
    qsc_sqrt_pipe #(
        .ROOT_W (R_W),
        .LANES  (1),
        .SB_W   ($bits(sb_b_t))
    ) u_dev_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .in_rad    (rad_b),
        .in_sb     (sb_b_in),
        .out_valid (vb_out),
        .out_root  (root_b),
        .out_sb    (sb_b_out)
    );

    // Stage 8: limit products and aligned dot products.
    logic                    v8_reg;
    logic [SPR_W-1:0]        spr_lhs_reg, spr_rhs_reg;
    logic [LIMP_W-1:0]       limp02_reg, limp01_reg;
    logic signed [CMP_W-1:0] x02_8_reg, x01_8_reg;
    logic [SUM_W-1:0]        sum8_reg;
    logic                    zero8_reg, last8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v8_reg <= vb_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            spr_lhs_reg <= SPR_W'(root_b[0]) << SPREAD_SHIFT;
            spr_rhs_reg <= SPR_W'(spread_reg) * SPR_W'(sb_b_out.sum);
            limp02_reg  <= LIMP_W'(opp_reg) * LIMP_W'(sb_b_out.p02);
            limp01_reg  <= LIMP_W'(adj_reg) * LIMP_W'(sb_b_out.p01);
            x02_8_reg   <= CMP_W'(sb_b_out.dot02) <<< COS_SH;
            x01_8_reg   <= CMP_W'(sb_b_out.dot01) <<< COS_SH;
            sum8_reg    <= sb_b_out.sum;
            zero8_reg   <= sb_b_out.zero;
            last8_reg   <= sb_b_out.last;
        end
    end

    // Stage 9: the three tests, and the width numerator and divisor.
    logic                    v9_reg;
    logic signed [CMP_W-1:0] lim02_s, lim01_s, opp_sum;
    logic                    spread_fail, opp_fail, adj_fail;
    logic [DEN_W-1:0]        den_next;
    logic                    ok9_reg, last9_reg;
    logic [NUM_W-1:0]        num9_reg;
    logic [DEN_W-1:0]        den9_reg;

    assign lim02_s     = $signed({2'b00, limp02_reg});
    assign lim01_s     = $signed({2'b00, limp01_reg});
    assign opp_sum     = x02_8_reg + lim02_s;
    assign spread_fail = (spr_lhs_reg > spr_rhs_reg);
    assign opp_fail    = (opp_sum > 0);
    assign adj_fail    = (x01_8_reg > lim01_s) || (x01_8_reg < -lim01_s);
    assign den_next    = (DEN_W'(dpi_reg) * DEN_W'(5)) << EXTRA;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok9_reg   <= !zero8_reg && !spread_fail && !opp_fail && !adj_fail;
            num9_reg  <= NUM_W'(sum8_reg) * NUM_W'(MM_SCALE) + NUM_W'(den_next >> 1);
            den9_reg  <= den_next;
            last9_reg <= last8_reg;
        end
    end

    // Stage 10: saturation check ahead of the divider.
    logic             v10_reg;
    logic [DIV_W-1:0] num10_reg;
    logic [DEN_W-1:0] den10_reg;
    sb_d_t            sb10_reg, sb_d_out;
    logic             vd_out;
    width_t           quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg <= 1'b0;
        end
        else if (adv)
        begin
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num10_reg <= DIV_W'(num9_reg);
            den10_reg <= den9_reg;
            sb10_reg  <= '{ok: ok9_reg,
                           sat: (den9_reg == '0) ||
                                (num9_reg >= (DIV_W'(den9_reg) << WIDTH_W)),
                           last: last9_reg};
        end
    end

    // Width = rounded numerator / divisor.
    qsc_div_pipe #(
        .QUO_W (WIDTH_W),
        .DEN_W (DEN_W),
        .SB_W  ($bits(sb_d_t))
    ) u_width_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v10_reg),
        .in_num    (num10_reg),
        .in_den    (den10_reg),
        .in_sb     (sb10_reg),
        .out_valid (vd_out),
        .out_quo   (quo),
        .out_sb    (sb_d_out)
    );

    // Output register holding one finished transaction.
    logic   is_square_reg, last_result_reg;
    width_t width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vd_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            is_square_reg   <= sb_d_out.ok;
            width_reg       <= !sb_d_out.ok ? '0 : (sb_d_out.sat ? WIDTH_MAX : quo);
            last_result_reg <= sb_d_out.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_square   = is_square_reg;
    assign width_mm    = width_reg;
    assign last_result = last_result_reg;

endmodule

// ===== hw/rtl/qsc_checker.sv =====
// Port-level checks for the quad squareness check, bound to the top level.
`timescale 1ns / 1ps

module qsc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic            is_square,
    input qsc_pkg::width_t width_mm,
    input logic            last_result
);

    // A waiting result transaction holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(width_mm) &&
        $stable(is_square) && $stable(last_result))
        else $error("result changed while stalled");

    // A rejected quad always reports zero width.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_square |-> width_mm == '0)
        else $error("rejected quad with nonzero width");

    // The input side stalls only while a result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input stalled without a waiting result");

    // A stalled output never advances the input side.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("input accepted while output stalled");

endmodule

bind quad_squareness_check_unit qsc_checker u_qsc_checker (.*);

// ===== dv/quad_squareness_check_unit_checker.sv =====
// Checker for the quad squareness check: predicts each verdict and compares it with the output.
`timescale 1ns / 1ps

module quad_squareness_check_unit_checker
    import qsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  cfg_index_t         cfg_index,
    input  cfg_word_t          cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] corner0_x,
    input  logic signed [15:0] corner0_y,
    input  logic signed [15:0] corner1_x,
    input  logic signed [15:0] corner1_y,
    input  logic signed [15:0] corner2_x,
    input  logic signed [15:0] corner2_y,
    input  logic signed [15:0] corner3_x,
    input  logic signed [15:0] corner3_y,
    input  logic               last_quad,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               is_square,
    input  width_t             width_mm,
    input  logic               last_result,
    output int                 mismatch_count,
    output int                 verdicts_pending
);

    typedef struct packed {
        logic   square;
        width_t width;
        logic   last;
    } verdict_t;

    verdict_t  verdict_queue[$];
    cfg_word_t dpi_reg;
    cfg_word_t spread_reg;
    cfg_word_t opp_reg;
    cfg_word_t adj_reg;

    assign verdicts_pending = verdict_queue.size();

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Side lengths, the three squareness tests and the width in millimetres.
    function automatic verdict_t judge_quad(input logic [3:0][15:0] qx,
                                            input logic [3:0][15:0] qy,
                                            input logic lq);
        longint            vx[4];
        longint            vy[4];
        longint unsigned   len[4];
        longint unsigned   sq;
        longint unsigned   total;
        longint unsigned   sumd2;
        longint unsigned   root;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   w;
        longint            d;
        longint            dot01;
        longint            dot02;
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        bit                ok;
        verdict_t          v;
        ok = 1;
        total = 0;
        w = 0;
        for (int j = 0; j < 4; j++)
        begin
            vx[j] = longint'($signed(qx[(j + 1) % 4])) - longint'($signed(qx[j]));
            vy[j] = longint'($signed(qy[(j + 1) % 4])) - longint'($signed(qy[j]));
            sq = longint'(vx[j] * vx[j]) + longint'(vy[j] * vy[j]);
            if (sq == 0)
                ok = 0;
            len[j] = int_sqrt(sq << 16);
            total = total + len[j];
        end
        if (ok)
        begin
            sumd2 = 0;
            for (int j = 0; j < 4; j++)
            begin
                d = longint'(4 * len[j]) - longint'(total);
                sumd2 = sumd2 + longint'(d * d);
            end
            root = int_sqrt(sumd2);
            if ((root << 15) > longint'(spread_reg) * total)
                ok = 0;

            // Opposite sides must point against each other.
            dot02 = (vx[0] * vx[2] + vy[0] * vy[2]) * 65536;
            lhs = dot02;
            lhs = -lhs * 65536;
            rhs = opp_reg;
            rhs = rhs * len[0];
            rhs = rhs * len[2];
            if (lhs < rhs)
                ok = 0;

            // Adjacent sides must be close to perpendicular.
            dot01 = (vx[0] * vx[1] + vy[0] * vy[1]) * 65536;
            lhs = dot01;
            if (lhs < 0)
                lhs = -lhs;
            lhs = lhs * 65536;
            rhs = adj_reg;
            rhs = rhs * len[0];
            rhs = rhs * len[1];
            if (lhs > rhs)
                ok = 0;
        end
        if (ok)
        begin
            if (dpi_reg == 0)
                w = WIDTH_MAX;
            else
            begin
                num = total * 8128;
                den = (longint'(dpi_reg) * 5) << 8;
                w = (num + den / 2) / den;
                if (w > WIDTH_MAX)
                    w = WIDTH_MAX;
            end
        end
        v.square = ok;
        v.width  = width_t'(w);
        v.last   = lq;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    initial
        mismatch_count = 0;

    // Track configuration, record each input transaction and check each result.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            dpi_reg    = DPI_RESET;
            spread_reg = SPREAD_RESET;
            opp_reg    = OPP_RESET;
            adj_reg    = ADJ_RESET;
            verdict_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    report_mismatch("result count", 1, 0);
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (is_square !== want.square)
                        report_mismatch("is_square", is_square, want.square);
                    if (width_mm !== want.width)
                        report_mismatch("width_mm", width_mm, want.width);
                    if (last_result !== want.last)
                        report_mismatch("last_result", last_result, want.last);
                end
            end
            if (in_valid && in_ready)
                verdict_queue.push_back(judge_quad(
                    {corner3_x, corner2_x, corner1_x, corner0_x},
                    {corner3_y, corner2_y, corner1_y, corner0_y}, last_quad));
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_DPI:    dpi_reg    = cfg_wdata;
                    REG_SPREAD: spread_reg = cfg_wdata;
                    REG_OPP:    opp_reg    = cfg_wdata;
                    REG_ADJ:    adj_reg    = cfg_wdata;
                    default:    ;
                endcase
            end
        end
    end

endmodule

// ===== dv/quad_squareness_check_unit_tb.sv =====
// Testbench top for the quad squareness check: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module quad_squareness_check_unit_tb;
    import qsc_pkg::*;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_write_en = 1'b0;
    cfg_index_t         cfg_index = REG_DPI;
    cfg_word_t          cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] cx[4];
    logic signed [15:0] cy[4];
    logic               last_quad = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               is_square;
    width_t             width_mm;
    logic               last_result;
    int                 mismatch_count;
    int                 verdicts_pending;
    bit                 calm = 0;

    initial
    begin
        for (int j = 0; j < 4; j++)
        begin
            cx[j] = '0;
            cy[j] = '0;
        end
    end

    quad_squareness_check_unit #(.COORD_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .corner0_x(cx[0]), .corner0_y(cy[0]), .corner1_x(cx[1]), .corner1_y(cy[1]),
        .corner2_x(cx[2]), .corner2_y(cy[2]), .corner3_x(cx[3]), .corner3_y(cy[3]),
        .last_quad(last_quad),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_square(is_square), .width_mm(width_mm), .last_result(last_result)
    );

    quad_squareness_check_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .corner0_x(cx[0]), .corner0_y(cy[0]), .corner1_x(cx[1]), .corner1_y(cy[1]),
        .corner2_x(cx[2]), .corner2_y(cy[2]), .corner3_x(cx[3]), .corner3_y(cy[3]),
        .last_quad(last_quad),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_square(is_square), .width_mm(width_mm), .last_result(last_result),
        .mismatch_count(mismatch_count), .verdicts_pending(verdicts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver stalls about 30 percent of cycles, except in calm stretches.
    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);

    initial
    begin
        #2000000;
        $display("quad_squareness_check_unit_tb failed");
        $finish;
    end

    // Write all four registers on consecutive cycles; called at a falling edge.
    task automatic write_config(input cfg_word_t dpi, input cfg_word_t spread,
                                input cfg_word_t opp, input cfg_word_t adj);
        cfg_word_t vals[4];
        vals = '{dpi, spread, opp, adj};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= cfg_index_t'(i);
            cfg_wdata    <= vals[i];
            @(negedge clk);
        end
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, then hold off until every verdict is back and the pipeline has drained.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // Present one quad and hold it until the transaction completes.
    task automatic send_quad(input logic signed [15:0] qx[4], input logic signed [15:0] qy[4],
                             input logic lq);
        for (int j = 0; j < 4; j++)
        begin
            cx[j] <= qx[j];
            cy[j] <= qy[j];
        end
        last_quad <= lq;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Square, or rectangle when stretched, from a corner and a side vector, with optional jitter.
    task automatic send_square(input int ox, input int oy, input int a, input int b,
                               input int jit, input int stretch);
        logic signed [15:0] qx[4];
        logic signed [15:0] qy[4];
        int                 px[4];
        int                 py[4];
        px = '{ox, ox + a, ox + a - b * stretch, ox - b * stretch};
        py = '{oy, oy + b, oy + b + a * stretch, oy + a * stretch};
        for (int j = 0; j < 4; j++)
        begin
            qx[j] = 16'(px[j] + $signed($urandom_range(0, 2 * jit)) - jit);
            qy[j] = 16'(py[j] + $signed($urandom_range(0, 2 * jit)) - jit);
        end
        send_quad(qx, qy, $urandom_range(0, 1));
    endtask

    task automatic send_random_quad();
        logic signed [15:0] qx[4];
        logic signed [15:0] qy[4];
        for (int j = 0; j < 4; j++)
        begin
            qx[j] = 16'($urandom);
            qy[j] = 16'($urandom);
        end
        send_quad(qx, qy, $urandom_range(0, 1));
    endtask

    // Mostly near-squares of varied size, some rectangles and some noise.
    task automatic random_phase(input int count);
        int side;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            side = ($urandom_range(0, 9) == 0) ? 8000 : 400;
            if (pick < 70)
                send_square($signed($urandom_range(0, 20000)) - 10000,
                            $signed($urandom_range(0, 20000)) - 10000,
                            $signed($urandom_range(0, 2 * side)) - side,
                            $signed($urandom_range(0, 2 * side)) - side,
                            $urandom_range(0, 3), 1);
            else if (pick < 80)
                send_square($signed($urandom_range(0, 2000)) - 1000,
                            $signed($urandom_range(0, 2000)) - 1000,
                            $signed($urandom_range(0, 2000)) - 1000,
                            $signed($urandom_range(0, 2000)) - 1000,
                            $urandom_range(0, 20), $urandom_range(0, 3));
            else
                send_random_quad();
        end
    endtask

    initial
    begin
        logic signed [15:0] ex[4];
        logic signed [15:0] ey[4];
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed quads under the reset configuration.
        send_square(0, 0, 160, 0, 0, 1);
        send_square(100, -50, 300, 400, 0, 1);
        send_square(5, 5, 0, 0, 0, 1);                 // all corners coincide
        ex = '{16'sd10, 16'sd10, 16'sd50, 16'sd90};
        ey = '{16'sd10, 16'sd10, 16'sd40, 16'sd10};
        send_quad(ex, ey, 1'b1);                       // one zero-length side
        ex = '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768};
        ey = '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767};
        send_quad(ex, ey, 1'b0);                       // largest square
        ex = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
        ey = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
        send_quad(ex, ey, 1'b1);                       // extreme zigzag
        send_square(0, 0, 400, 0, 0, 2);               // rectangle
        send_square(0, 0, 400, 30, 0, 1);
        send_square(0, 0, 1, 0, 0, 1);
        send_random_quad();
        random_phase(240);
        drain_pipeline();

        // Lowest limits and resolution.
        write_config(16'd1, 16'd0, 16'd0, 16'd0);
        send_square(0, 0, 200, 0, 0, 1);
        send_square(0, 0, 8000, 0, 0, 1);
        random_phase(100);
        drain_pipeline();                              // sender waits for every verdict
        random_phase(150);
        drain_pipeline();

        // Highest values, tiny width rounds to zero; no idling here.
        calm = 1;
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_square(0, 0, 1, 0, 0, 1);
        send_square(0, 0, 0, 1, 0, 1);
        random_phase(250);
        drain_pipeline();
        calm = 0;

        // Zero resolution saturates the width.
        write_config(16'd0, 16'd3000, 16'd60000, 16'd3000);
        send_square(0, 0, 300, 0, 0, 1);
        random_phase(250);
        drain_pipeline();

        // Random settings.
        for (int p = 0; p < 2; p++)
        begin
            write_config(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 8000)),
                         16'($urandom_range(50000, 65535)), 16'($urandom_range(0, 8000)));
            random_phase(250);
            drain_pipeline();
        end

        in_valid <= 1'b0;
        drain_pipeline();
        if (mismatch_count == 0)
            $display("quad_squareness_check_unit_tb passed");
        else
            $display("quad_squareness_check_unit_tb failed");
        $finish;
    end

endmodule
